### sv/svw_pkg.sv
// Shared types and constants for the streaming sample variance core.
// Holds field widths, the controller state enum and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package svw_pkg;

   // Field and state widths
   localparam int SAMPLE_W = 32;
   localparam int MEAN_W   = 48;
   localparam int DIFF_W   = MEAN_W + 1;
   localparam int M2_W     = 64;
   localparam int CNT_W    = 17;
   localparam int VAR_W    = 63;
   localparam int FRAC_SH  = 16;

   // Run length limit
   localparam int MAX_SAMPLES = 65536;

   // Divider and multiplier sequencing
   localparam int DIV_W          = 64;
   localparam int MEAN_DIV_STEPS = MEAN_W;
   localparam int VAR_DIV_STEPS  = DIV_W;
   localparam int HALF_W         = MEAN_W / 2;
   localparam int ACC_W          = 2 * MEAN_W;
   localparam int MUL_STEPS      = 4;
   localparam int STEP_W         = 7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MDIV,
      ST_MEAN,
      ST_DEV,
      ST_MUL,
      ST_SUM,
      ST_TAIL,
      ST_VDIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       div_load_mean;
      logic       div_step;
      logic       mean_upd;
      logic       dev_calc;
      logic       mul_pp;
      logic [1:0] mul_idx;
      logic       mul_acc;
      logic       sum_upd;
      logic       tail;
      logic       div_load_var;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic count_full;
      logic count_ge2;
      logic last;
      logic out_free;
   } sts_type;

endpackage

### sv/svw_div.sv
// Radix-2 restoring divider: 64-bit dividend by 17-bit divisor, one bit per step.
// Depends on svw_pkg for widths. Step count is set by the caller.
`timescale 1ns / 1ps

module svw_div (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic [svw_pkg::DIV_W-1:0]   dividend,
   input  logic [svw_pkg::CNT_W-1:0]   divisor,
   output logic [svw_pkg::DIV_W-1:0]   quotient
);
   import svw_pkg::*;

   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W:0]   trial;
   logic             fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (step) begin
         rem_in = fits ? CNT_W'(trial - {1'b0, dvs_ff}) : trial[CNT_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;

endmodule

### sv/svw_datapath.sv
// Datapath of the variance core: run state, deviations, partial-product
// multiplier, saturating sum and result word register. Uses svw_pkg, svw_div.
`timescale 1ns / 1ps

module svw_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  svw_pkg::cmd_type                   cmd,
   output svw_pkg::sts_type                   sts,
   input  logic signed [svw_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [svw_pkg::VAR_W-1:0]          rsp_variance,
   output logic                               rsp_valid_res,
   output logic                               rsp_saturated
);
   import svw_pkg::*;

   // Run state
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic [M2_W-1:0]          m2_ff, m2_in;
   logic                     ovf_ff, ovf_in;

   // Per-sample working registers
   logic signed [MEAN_W-1:0] x_ff, x_in;
   logic [MEAN_W-1:0]        mag_a_ff, mag_a_in;
   logic [MEAN_W-1:0]        mag_b_ff, mag_b_in;
   logic                     neg_ff, neg_in;
   logic                     last_ff, last_in;
   logic [2*HALF_W-1:0]      pp_ff, pp_in;
   logic [1:0]               pp_sel_ff, pp_sel_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     res_ok_ff, res_ok_in;

   // Result word
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VAR_W-1:0]         var_ff, var_in;
   logic                     res_valid_ff, res_valid_in;
   logic                     res_sat_ff, res_sat_in;

   // Divider interface
   logic [DIV_W-1:0]         div_dividend;
   logic [CNT_W-1:0]         div_divisor;
   logic [DIV_W-1:0]         div_quo;

   // Combinational helpers
   logic signed [MEAN_W-1:0] x_now;
   logic signed [DIFF_W-1:0] d1, d2, step_s, mean_sum;
   logic [DIFF_W-1:0]        d1_mag, d2_mag;
   logic [HALF_W-1:0]        a_half, b_half;
   logic [ACC_W-1:0]         pp_shifted;
   logic [M2_W:0]            m2_sum;
   logic                     out_free;

   svw_div u_div (
      .clock    (clock),
      .load     (cmd.div_load_mean | cmd.div_load_var),
      .step     (cmd.div_step),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo)
   );

   // Form both deviations, from the incoming and the stored sample, and the updated mean
   always_comb begin
      x_now  = {req_sample, {FRAC_SH{1'b0}}};
      d1     = DIFF_W'(x_now) - DIFF_W'(mean_ff);
      d1_mag = d1[DIFF_W-1] ? DIFF_W'(-d1) : DIFF_W'(d1);
      d2     = DIFF_W'(x_ff) - DIFF_W'(mean_ff);
      d2_mag = d2[DIFF_W-1] ? DIFF_W'(-d2) : DIFF_W'(d2);
      step_s = neg_ff ? -$signed({1'b0, div_quo[MEAN_W-1:0]})
                      : $signed({1'b0, div_quo[MEAN_W-1:0]});
      mean_sum = DIFF_W'(mean_ff) + step_s;
   end

   // Divider operand select: mean step or final variance
   always_comb begin
      if (cmd.div_load_var) begin
         div_dividend = m2_ff;
         div_divisor  = count_ff - CNT_W'(1);
      end else begin
         div_dividend = {d1_mag[MEAN_W-1:0], {(DIV_W-MEAN_W){1'b0}}};
         div_divisor  = count_ff + CNT_W'(1);
      end
   end

   // Pick the operand halves for one partial product, align the last one and form the sum update
   always_comb begin
      a_half     = cmd.mul_idx[1] ? mag_a_ff[MEAN_W-1:HALF_W] : mag_a_ff[HALF_W-1:0];
      b_half     = cmd.mul_idx[0] ? mag_b_ff[MEAN_W-1:HALF_W] : mag_b_ff[HALF_W-1:0];
      pp_shifted = ACC_W'(pp_ff);
      if (pp_sel_ff[0]) pp_shifted = pp_shifted << HALF_W;
      if (pp_sel_ff[1]) pp_shifted = pp_shifted << HALF_W;
      m2_sum = {1'b0, m2_ff} + (M2_W + 1)'(acc_ff[ACC_W-1:ACC_W-MEAN_W]);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next-state for all datapath registers
   always_comb begin
      count_in     = count_ff;
      mean_in      = mean_ff;
      m2_in        = m2_ff;
      ovf_in       = ovf_ff;
      x_in         = x_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      pp_in        = pp_ff;
      pp_sel_in    = pp_sel_ff;
      acc_in       = acc_ff;
      res_ok_in    = res_ok_ff;
      var_in       = var_ff;
      res_valid_in = res_valid_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         last_in = req_last;
         if (sts.count_full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
            x_in     = x_now;
            mag_a_in = d1_mag[MEAN_W-1:0];
            neg_in   = d1[DIFF_W-1];
         end
      end
      if (cmd.mean_upd) begin
         mean_in = mean_sum[MEAN_W-1:0];
      end
      if (cmd.dev_calc) begin
         mag_b_in = d2_mag[MEAN_W-1:0];
         acc_in   = '0;
      end
      if (cmd.mul_pp) begin
         pp_in     = a_half * b_half;
         pp_sel_in = cmd.mul_idx;
      end
      if (cmd.mul_acc) begin
         acc_in = acc_ff + pp_shifted;
      end
      if (cmd.sum_upd) begin
         if (m2_sum[M2_W]) begin
            m2_in  = '1;
            ovf_in = 1'b1;
         end else begin
            m2_in = m2_sum[M2_W-1:0];
         end
      end
      if (cmd.tail) begin
         res_ok_in = sts.count_ge2;
      end
      // Load the result word, then drop the run
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         res_valid_in = res_ok_ff;
         res_sat_in   = ovf_ff;
         if (!res_ok_ff)             var_in = '0;
         else if (div_quo[DIV_W-1])  var_in = '1;
         else                        var_in = div_quo[VAR_W-1:0];
         count_in = '0;
         mean_in  = '0;
         m2_in    = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mean_ff      <= '0;
         m2_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         m2_ff        <= m2_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      mag_a_ff     <= mag_a_in;
      mag_b_ff     <= mag_b_in;
      neg_ff       <= neg_in;
      last_ff      <= last_in;
      pp_ff        <= pp_in;
      pp_sel_ff    <= pp_sel_in;
      acc_ff       <= acc_in;
      res_ok_ff    <= res_ok_in;
      var_ff       <= var_in;
      res_valid_ff <= res_valid_in;
      res_sat_ff   <= res_sat_in;
   end

   // Status back to the controller
   always_comb begin
      sts.count_full = (count_ff == CNT_W'(MAX_SAMPLES));
      sts.count_ge2  = (count_ff >= CNT_W'(2));
      sts.last       = last_ff;
      sts.out_free   = out_free;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_variance  = var_ff;
   assign rsp_valid_res = res_valid_ff;
   assign rsp_saturated = res_sat_ff;

   // A new result word never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded while output word still pending");

   // A sample hitting a full count marks the run saturated
   a_full_ovf: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.count_full) |=> ovf_ff)
      else $error("full count did not set overflow");

   // The run is cleared once its result is loaded
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == '0 && m2_ff == '0 && !ovf_ff))
      else $error("run state not cleared after result");

   // The count never passes the run limit
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond limit");

endmodule

### sv/svw_ctrl.sv
// Controller of the variance core: sequences accept, mean division, multiply,
// sum update and final division. Uses svw_pkg types; drives the datapath commands.
`timescale 1ns / 1ps

module svw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  svw_pkg::sts_type sts,
   output svw_pkg::cmd_type cmd
);
   import svw_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = sts.count_full ? ST_TAIL : ST_MDIV;
               cnt_in   = STEP_W'(MEAN_DIV_STEPS - 1);
            end
         end
         ST_MDIV: begin
            if (cnt_ff == '0) state_in = ST_MEAN;
            else              cnt_in   = cnt_ff - STEP_W'(1);
         end
         ST_MEAN: state_in = ST_DEV;
         ST_DEV: begin
            state_in = ST_MUL;
            cnt_in   = '0;
         end
         ST_MUL: begin
            if (cnt_ff == STEP_W'(MUL_STEPS)) state_in = ST_SUM;
            else                              cnt_in   = cnt_ff + STEP_W'(1);
         end
         ST_SUM: state_in = ST_TAIL;
         ST_TAIL: begin
            if (!sts.last) begin
               state_in = ST_IDLE;
            end else if (sts.count_ge2) begin
               state_in = ST_VDIV;
               cnt_in   = STEP_W'(VAR_DIV_STEPS - 1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_VDIV: begin
            if (cnt_ff == '0) state_in = ST_EMIT;
            else              cnt_in   = cnt_ff - STEP_W'(1);
         end
         ST_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept        = accept;
            cmd.div_load_mean = accept && !sts.count_full;
         end
         ST_MDIV: cmd.div_step = 1'b1;
         ST_MEAN: cmd.mean_upd = 1'b1;
         ST_DEV:  cmd.dev_calc = 1'b1;
         ST_MUL: begin
            cmd.mul_pp  = (cnt_ff < STEP_W'(MUL_STEPS));
            cmd.mul_idx = cnt_ff[1:0];
            cmd.mul_acc = (cnt_ff != '0);
         end
         ST_SUM:  cmd.sum_upd = 1'b1;
         ST_TAIL: begin
            cmd.tail         = 1'b1;
            cmd.div_load_var = sts.last && sts.count_ge2;
         end
         ST_VDIV: cmd.div_step = 1'b1;
         ST_EMIT: cmd.emit     = sts.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Words are only taken while idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (state_ff == ST_IDLE))
      else $error("word accepted outside idle");

   // The final division is only started for a last sample of a long enough run
   a_var_load: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load_var |-> (sts.last && sts.count_ge2))
      else $error("variance division started without a valid run");

   // An accepted non-full sample always enters the mean division
   a_mdiv_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !sts.count_full) |=> (state_ff == ST_MDIV))
      else $error("accepted sample did not start mean division");

endmodule

### sv/sample_variance_welford_core.sv
// Streaming unbiased sample variance (Welford recurrence) in fixed point.
// Input channel req_*: req_sample is a signed Q16.16 word, req_last marks the
// final word of a run. A word is taken at a clock edge with req_valid high and
// req_stall low. Result channel rsp_*: one word per run, at its last sample,
// carrying rsp_variance (unsigned Q47.16, clamped), rsp_valid_res (low for runs
// shorter than two samples) and rsp_saturated (count or sum hit its limit).
// A new sample is taken only while idle; req_stall stays high until the last
// one is through: the one-bit-per-cycle divider forms the mean step, then the
// mean and deviation are updated, the 24x24 partial-product multiplier runs,
// and the sum and run end are updated before the core returns to idle.
// For a last sample, the divider forms M2/(n-1) when the run has two or more
// samples, and the result word is then loaded into the output register.
// The result sits in an output register: a stalled result word holds while the
// next run's samples are already accepted; only a second result waits for it.
// Reset (synchronous, active high) clears the run and drops any pending result.
// Uses svw_pkg, svw_ctrl, svw_datapath, svw_div.
`timescale 1ns / 1ps

module sample_variance_welford_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [svw_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [svw_pkg::VAR_W-1:0]           rsp_variance,
   output logic                                rsp_valid_res,
   output logic                                rsp_saturated
);
   import svw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   svw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and run state
   svw_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_variance  (rsp_variance),
      .rsp_valid_res (rsp_valid_res),
      .rsp_saturated (rsp_saturated)
   );

endmodule
